/* rtl/lts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lts_pkg
// Types and constants shared by the lottery task scheduler modules.
// ----------------------------------------------------------------------------
package lts_pkg;

    localparam int MaxReady       = 16;
    localparam int MaxCompensated = 16;
    localparam logic [7:0]  IdleId      = 8'd255;
    localparam logic [13:0] BaseTickets = 14'd10;
    localparam logic [9:0]  QuantumRst  = 10'd10;

    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_LOAD    = 3'd1,
        ACT_UNBLOCK = 3'd2,
        ACT_BLOCK   = 3'd3,
        ACT_EXIT    = 3'd4
    } t_action;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_READY_FULL = 2'd1;
    localparam logic [1:0] ST_COMP_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  task_id;
        logic [31:0] draw;
    } t_in;

    typedef struct packed {
        logic [7:0] next_task;
        logic       drew_lottery;
        logic [1:0] status;
    } t_out;

    // divider handshake between control and the shared divider
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [17:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [17:0] remainder;
    } t_div_rsp;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH,
        S_CSCAN_RD, S_CSCAN,
        S_PUSH_RD, S_PUSH, S_PUSH_WR,
        S_CPUT, S_CPUT_DIV,
        S_RM_RD, S_RM, S_RM_SH_RD, S_RM_SH,
        S_DRAW_DIV, S_DRAW_RD, S_DRAW, S_RESET_TK,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

/* rtl/lts_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lts_div
// Restoring radix-2 divider, one quotient bit per cycle, 32 bit dividend.
// ----------------------------------------------------------------------------
module lts_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lts_pkg::t_div_req i_req,
    output lts_pkg::t_div_rsp      o_rsp
);
    logic [31:0] r_q, n_q;
    logic [18:0] r_rem, n_rem;
    logic [17:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [18:0] w_sh;

    always_comb begin
        w_sh  = {r_rem[17:0], r_q[31]};
        n_q   = {r_q[30:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {1'b0, r_den}) begin
            n_rem = w_sh - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_q;
    assign o_rsp.remainder = r_rem[17:0];
endmodule
`default_nettype wire

/* rtl/lottery_task_scheduler_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lottery_task_scheduler_unit
// Lottery scheduler: ready list and compensation table in RAM, one event
// at a time.
// ----------------------------------------------------------------------------
// One event is taken when start is high and busy low; its result shows on
// o_result for one cycle with o_done high and cannot be held off. An event
// is shortest for an event such as a tick that does not draw or an unknown
// action, and longest for a block that saves compensation, removes an entry
// and draws. The table scan and the draw walk one entry per cycle, while the
// list search and shifts alternate a read state with a compare or write
// state, all through a single read port per RAM; the modulo of the draw and
// the compensation quotient both use the shared bit-serial divider. No clearing pass follows reset.
module lottery_task_scheduler_unit #(
    parameter int MAX_READY       = lts_pkg::MaxReady,
    parameter int MAX_COMPENSATED = lts_pkg::MaxCompensated
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire lts_pkg::t_in  i_item,
    output logic               o_done,
    output lts_pkg::t_out      o_result,
    input  wire logic          i_cfg_we,
    input  wire logic [9:0]    i_cfg_data
);
    localparam int RW = $clog2(MAX_READY);
    localparam int CW = (MAX_COMPENSATED > 1) ? $clog2(MAX_COMPENSATED) : 1;
    localparam int RC = $clog2(MAX_READY + 1);
    localparam int CC = $clog2(MAX_COMPENSATED + 1);

    // ready list RAM: {id, tickets}
    logic [21:0] r_rmem [MAX_READY];
    logic [21:0] r_rrd;
    logic        w_rwe;
    logic [RW-1:0] w_rwa, w_rra;
    logic [21:0] w_rwd;
    // compensation RAM: {id, mult}
    logic [17:0] r_cmem [MAX_COMPENSATED];
    logic [17:0] r_crd;
    logic        w_cwe;
    logic [CW-1:0] w_cwa, w_cra;
    logic [17:0] w_cwd;
    logic [MAX_COMPENSATED-1:0] r_cval, n_cval;

    always_ff @(posedge i_clk) begin
        if (w_rwe) r_rmem[w_rwa] <= w_rwd;
        r_rrd <= r_rmem[w_rra];
    end
    always_ff @(posedge i_clk) begin
        if (w_cwe) r_cmem[w_cwa] <= w_cwd;
        r_crd <= r_cmem[w_cra];
    end

    lts_pkg::t_state r_st, n_st;
    lts_pkg::t_in    r_it, n_it;
    logic [9:0]  r_q;
    logic [RC-1:0] r_cnt, n_cnt, r_i, n_i;
    logic [CC-1:0] r_c, n_c;
    logic [17:0] r_tot, n_tot, r_sum, n_sum;
    logic [9:0]  r_tick, n_tick;
    logic [7:0]  r_run, n_run, r_nxt, n_nxt;
    logic        r_drew, n_drew;
    logic [1:0]  r_stat, n_stat;
    logic [13:0] r_tk, n_tk;
    logic [CC-1:0] r_slot, n_slot;
    logic [CC-1:0] r_free, n_free;
    logic        r_hit, n_hit;
    logic [17:0] r_win, n_win;
    logic        r_out, n_out;

    lts_pkg::t_div_req w_dreq;
    lts_pkg::t_div_rsp w_drsp;
    lts_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= lts_pkg::S_IDLE; r_q <= lts_pkg::QuantumRst;
            r_cnt <= '0; r_tot <= '0; r_tick <= '0; r_run <= lts_pkg::IdleId;
            r_cval <= '0; r_out <= 1'b0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_tot <= n_tot; r_tick <= n_tick;
            r_run <= n_run; r_cval <= n_cval; r_out <= n_out;
            if (i_cfg_we) r_q <= i_cfg_data;
        end
    end
    always_ff @(posedge i_clk) begin
        r_it <= n_it; r_i <= n_i; r_c <= n_c; r_sum <= n_sum; r_nxt <= n_nxt;
        r_drew <= n_drew; r_stat <= n_stat; r_tk <= n_tk; r_slot <= n_slot;
        r_free <= n_free; r_hit <= n_hit; r_win <= n_win;
    end

    logic [27:0] w_tk28;
    logic [13:0] w_tick14;
    always_comb begin
        n_st = r_st; n_it = r_it; n_cnt = r_cnt; n_i = r_i; n_c = r_c;
        n_tot = r_tot; n_sum = r_sum; n_tick = r_tick; n_run = r_run;
        n_nxt = r_nxt; n_drew = r_drew; n_stat = r_stat; n_tk = r_tk;
        n_slot = r_slot; n_free = r_free; n_hit = r_hit;
        n_win = r_win; n_cval = r_cval; n_out = 1'b0;
        w_rwe = 1'b0; w_rwa = '0; w_rra = '0; w_rwd = '0;
        w_cwe = 1'b0; w_cwa = '0; w_cra = '0; w_cwd = '0;
        w_dreq = '0;
        w_tk28 = 28'(r_crd[9:0]) * 28'(lts_pkg::BaseTickets);
        w_tick14 = 14'(r_tick) + 14'd1;
        case (r_st)
            lts_pkg::S_IDLE: begin
                if (start) begin
                    n_it = i_item; n_st = lts_pkg::S_DISPATCH;
                    n_nxt = r_run; n_drew = 1'b0; n_stat = lts_pkg::ST_OK;
                end
            end
            lts_pkg::S_DISPATCH: begin
                n_st = lts_pkg::S_DONE;
                n_tk = lts_pkg::BaseTickets;
                n_c = '0; n_hit = 1'b0; n_free = CC'(MAX_COMPENSATED);
                case (r_it.action)
                    lts_pkg::ACT_TICK: begin
                        if (r_run == lts_pkg::IdleId) begin
                            if (r_cnt != '0) n_st = lts_pkg::S_DRAW_DIV;
                        end else if (w_tick14[9:0] >= r_q) begin
                            n_tick = '0;
                            if (r_cnt != '0) n_st = lts_pkg::S_DRAW_DIV;
                            else n_nxt = lts_pkg::IdleId;
                        end else begin
                            n_tick = w_tick14[9:0];
                        end
                    end
                    lts_pkg::ACT_LOAD: begin
                        if (r_cnt >= RC'(MAX_READY)) n_stat = lts_pkg::ST_READY_FULL;
                        else begin
                            n_i = r_cnt; n_st = lts_pkg::S_PUSH_RD;
                        end
                    end
                    lts_pkg::ACT_UNBLOCK: begin
                        if (r_cnt >= RC'(MAX_READY)) n_stat = lts_pkg::ST_READY_FULL;
                        else n_st = lts_pkg::S_CSCAN_RD;
                    end
                    lts_pkg::ACT_BLOCK, lts_pkg::ACT_EXIT: begin
                        n_i = '0;
                        if (r_run == lts_pkg::IdleId) n_st = lts_pkg::S_RESET_TK;
                        else if (r_it.action == lts_pkg::ACT_BLOCK && r_tick < r_q)
                            n_st = lts_pkg::S_CSCAN_RD;
                        else n_st = lts_pkg::S_RM_RD;
                    end
                    default: ;
                endcase
            end
            // walk compensation table; one entry per cycle
            lts_pkg::S_CSCAN_RD: begin
                w_cra = CW'(r_c); n_st = lts_pkg::S_CSCAN;
            end
            lts_pkg::S_CSCAN: begin
                if (r_cval[CW'(r_c)] && r_crd[17:10] ==
                    ((r_it.action == lts_pkg::ACT_UNBLOCK) ? r_it.task_id : r_run)) begin
                    n_hit = 1'b1; n_slot = r_c;
                    n_tk = w_tk28[13:0];
                end else if (!r_cval[CW'(r_c)] && r_free == CC'(MAX_COMPENSATED))
                    n_free = r_c;
                if ((r_cval[CW'(r_c)] && r_crd[17:10] ==
                    ((r_it.action == lts_pkg::ACT_UNBLOCK) ? r_it.task_id : r_run))
                    || r_c == CC'(MAX_COMPENSATED - 1)) begin
                    if (r_it.action == lts_pkg::ACT_UNBLOCK) begin
                        n_i = r_cnt; n_st = lts_pkg::S_PUSH_RD;
                    end else n_st = lts_pkg::S_CPUT;
                end else begin
                    n_c = r_c + CC'(1); w_cra = CW'(r_c + CC'(1));
                end
            end
            lts_pkg::S_CPUT: begin
                if (r_hit) n_st = lts_pkg::S_RM_RD;
                else if (r_free == CC'(MAX_COMPENSATED)) begin
                    n_stat = lts_pkg::ST_COMP_FULL; n_st = lts_pkg::S_RM_RD;
                end else begin
                    w_dreq.start = 1'b1;
                    w_dreq.dividend = 32'(r_q);
                    w_dreq.divisor = (r_tick == '0) ? 18'd1 : 18'(r_tick);
                    n_st = lts_pkg::S_CPUT_DIV;
                end
            end
            lts_pkg::S_CPUT_DIV: begin
                if (w_drsp.done) begin
                    w_cwe = 1'b1; w_cwa = CW'(r_free);
                    w_cwd = {r_run, w_drsp.quotient[9:0]};
                    n_cval[CW'(r_free)] = 1'b1;
                    n_st = lts_pkg::S_RM_RD;
                end
            end
            // shift list up by one from the tail, then write the head
            lts_pkg::S_PUSH_RD: begin
                if (r_i == '0) n_st = lts_pkg::S_PUSH_WR;
                else begin
                    w_rra = RW'(r_i - RC'(1)); n_st = lts_pkg::S_PUSH;
                end
            end
            lts_pkg::S_PUSH: begin
                w_rwe = 1'b1; w_rwa = RW'(r_i); w_rwd = r_rrd;
                n_i = r_i - RC'(1); n_st = lts_pkg::S_PUSH_RD;
            end
            lts_pkg::S_PUSH_WR: begin
                w_rwe = 1'b1; w_rwa = '0; w_rwd = {r_it.task_id, r_tk};
                n_cnt = r_cnt + RC'(1);
                n_tot = r_tot + 18'(r_tk);
                if (r_hit) n_cval[CW'(r_slot)] = 1'b0;
                n_st = lts_pkg::S_DONE;
            end
            // find newest entry of the running task
            lts_pkg::S_RM_RD: begin
                if (r_i >= r_cnt) n_st = lts_pkg::S_RESET_TK;
                else begin
                    w_rra = RW'(r_i); n_st = lts_pkg::S_RM;
                end
            end
            lts_pkg::S_RM: begin
                if (r_rrd[21:14] == r_run) begin
                    n_tot = r_tot - 18'(r_rrd[13:0]);
                    n_st = lts_pkg::S_RM_SH_RD;
                end else begin
                    n_i = r_i + RC'(1); n_st = lts_pkg::S_RM_RD;
                end
            end
            lts_pkg::S_RM_SH_RD: begin
                if (r_i + RC'(1) >= r_cnt) begin
                    n_cnt = r_cnt - RC'(1); n_st = lts_pkg::S_RESET_TK;
                end else begin
                    w_rra = RW'(r_i + RC'(1)); n_st = lts_pkg::S_RM_SH;
                end
            end
            lts_pkg::S_RM_SH: begin
                w_rwe = 1'b1; w_rwa = RW'(r_i); w_rwd = r_rrd;
                n_i = r_i + RC'(1); n_st = lts_pkg::S_RM_SH_RD;
            end
            lts_pkg::S_RESET_TK: begin
                n_tick = '0;
                if (r_cnt == '0) begin
                    n_nxt = lts_pkg::IdleId; n_st = lts_pkg::S_DONE;
                end else n_st = lts_pkg::S_DRAW_DIV;
            end
            lts_pkg::S_DRAW_DIV: begin
                if (r_tot == '0) begin
                    n_win = '0; n_i = '0; n_sum = '0; n_st = lts_pkg::S_DRAW;
                    w_rra = '0;
                end else begin
                    w_dreq.start = 1'b1; w_dreq.dividend = r_it.draw;
                    w_dreq.divisor = r_tot; n_st = lts_pkg::S_DRAW_RD;
                end
            end
            lts_pkg::S_DRAW_RD: begin
                if (w_drsp.done) begin
                    n_win = w_drsp.remainder; n_i = '0; n_sum = '0;
                    w_rra = '0; n_st = lts_pkg::S_DRAW;
                end
            end
            // walk list summing tickets; rewrite each entry to base tickets
            lts_pkg::S_DRAW: begin
                n_sum = r_sum + 18'(r_rrd[13:0]);
                w_rwe = 1'b1; w_rwa = RW'(r_i);
                w_rwd = {r_rrd[21:14], lts_pkg::BaseTickets};
                if (r_i == '0 || r_win >= r_sum) n_nxt = r_rrd[21:14];
                if (r_i != '0 && r_win < r_sum) n_nxt = r_nxt;
                if (r_i + RC'(1) >= r_cnt) begin
                    n_drew = 1'b1;
                    n_tot = 18'(r_cnt) * 18'(lts_pkg::BaseTickets);
                    n_st = lts_pkg::S_DONE;
                end else begin
                    n_i = r_i + RC'(1); w_rra = RW'(r_i + RC'(1));
                end
            end
            lts_pkg::S_DONE: begin
                n_run = r_nxt; n_out = 1'b1; n_st = lts_pkg::S_IDLE;
            end
            default: n_st = lts_pkg::S_IDLE;
        endcase
    end

    assign busy   = (r_st != lts_pkg::S_IDLE);
    assign o_done = r_out;
    assign o_result.next_task    = r_run;
    assign o_result.drew_lottery = r_drew;
    assign o_result.status       = r_stat;

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= RC'(MAX_READY)) else $error("ready count overflow");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe held");
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("busy with result");
`endif
endmodule
`default_nettype wire

/* sim/lottery_task_scheduler_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lottery_task_scheduler_unit_test
// Drives scheduling events into the lottery scheduler with random gaps. It
// predicts each result from its own copy of the ready list, the compensation
// table and the quantum, and checks every result field.
// ----------------------------------------------------------------------------
module lottery_task_scheduler_unit_test;

    class sched_scoreboard;
        logic [7:0]  rdy_id [lts_pkg::MaxReady];
        logic [13:0] rdy_tk [lts_pkg::MaxReady];
        int          rdy_cnt;
        logic [17:0] tk_total;
        logic [9:0]  tick_cnt;
        logic [7:0]  running;
        logic [7:0]  cmp_id [lts_pkg::MaxCompensated];
        logic [9:0]  cmp_mul [lts_pkg::MaxCompensated];
        bit          cmp_vld [lts_pkg::MaxCompensated];
        logic [9:0]  quantum;
        lts_pkg::t_out expected_q[$];
        int          errors;

        function new();
            rdy_cnt  = 0;
            tk_total = '0;
            tick_cnt = '0;
            running  = lts_pkg::IdleId;
            quantum  = lts_pkg::QuantumRst;
            errors   = 0;
            foreach (cmp_vld[i]) cmp_vld[i] = 0;
        endfunction

        function bit insert_front(logic [7:0] id, logic [13:0] tickets);
            if (rdy_cnt >= lts_pkg::MaxReady) return 0;
            for (int i = rdy_cnt; i > 0; i--) begin
                rdy_id[i] = rdy_id[i-1];
                rdy_tk[i] = rdy_tk[i-1];
            end
            rdy_id[0] = id;
            rdy_tk[0] = tickets;
            rdy_cnt++;
            tk_total = tk_total + 18'(tickets);
            return 1;
        endfunction

        function logic [7:0] draw_winner(logic [31:0] draw);
            logic [31:0] win;
            logic [31:0] sum;
            logic [7:0]  winner;
            win    = (tk_total != 0) ? draw % 32'(tk_total) : 32'd0;
            sum    = 0;
            winner = rdy_id[rdy_cnt-1];
            for (int i = 0; i < rdy_cnt; i++) begin
                sum += 32'(rdy_tk[i]);
                if (win < sum) begin
                    winner = rdy_id[i];
                    break;
                end
            end
            for (int i = 0; i < rdy_cnt; i++) rdy_tk[i] = lts_pkg::BaseTickets;
            tk_total = 18'(rdy_cnt * 10);
            return winner;
        endfunction

        function bit store_comp(logic [7:0] id, logic [9:0] ticks);
            logic [9:0] used;
            used = (ticks != 0) ? ticks : 10'd1;
            foreach (cmp_vld[i])
                if (cmp_vld[i] && cmp_id[i] == id) return 1;
            foreach (cmp_vld[i])
                if (!cmp_vld[i]) begin
                    cmp_vld[i] = 1;
                    cmp_id[i]  = id;
                    cmp_mul[i] = quantum / used;
                    return 1;
                end
            return 0;
        endfunction

        function void drop_task(logic [7:0] id);
            for (int i = 0; i < rdy_cnt; i++)
                if (rdy_id[i] == id) begin
                    tk_total = tk_total - 18'(rdy_tk[i]);
                    for (int j = i; j + 1 < rdy_cnt; j++) begin
                        rdy_id[j] = rdy_id[j+1];
                        rdy_tk[j] = rdy_tk[j+1];
                    end
                    rdy_cnt--;
                    return;
                end
        endfunction

        function void note_event(lts_pkg::t_in ev);
            lts_pkg::t_out r;
            int    slot;
            logic [13:0] tickets;
            r.next_task    = running;
            r.drew_lottery = 0;
            r.status       = lts_pkg::ST_OK;
            case (ev.action)
                lts_pkg::ACT_TICK: begin
                    if (running == lts_pkg::IdleId) begin
                        if (rdy_cnt > 0) begin
                            r.next_task    = draw_winner(ev.draw);
                            r.drew_lottery = 1;
                        end
                    end else begin
                        tick_cnt = tick_cnt + 10'd1;
                        if (tick_cnt >= quantum) begin
                            tick_cnt = '0;
                            if (rdy_cnt > 0) begin
                                r.next_task    = draw_winner(ev.draw);
                                r.drew_lottery = 1;
                            end else begin
                                r.next_task = lts_pkg::IdleId;
                            end
                        end
                    end
                end
                lts_pkg::ACT_LOAD: begin
                    if (!insert_front(ev.task_id, lts_pkg::BaseTickets))
                        r.status = lts_pkg::ST_READY_FULL;
                end
                lts_pkg::ACT_UNBLOCK: begin
                    slot    = -1;
                    tickets = lts_pkg::BaseTickets;
                    foreach (cmp_vld[i])
                        if (slot < 0 && cmp_vld[i] && cmp_id[i] == ev.task_id) begin
                            slot    = i;
                            tickets = 14'(cmp_mul[i] * 10);
                        end
                    if (!insert_front(ev.task_id, tickets)) r.status = lts_pkg::ST_READY_FULL;
                    else if (slot >= 0) cmp_vld[slot] = 0;
                end
                lts_pkg::ACT_BLOCK, lts_pkg::ACT_EXIT: begin
                    if (running != lts_pkg::IdleId) begin
                        if (ev.action == lts_pkg::ACT_BLOCK && tick_cnt < quantum)
                            if (!store_comp(running, tick_cnt))
                                r.status = lts_pkg::ST_COMP_FULL;
                        drop_task(running);
                    end
                    tick_cnt = '0;
                    if (rdy_cnt == 0) begin
                        r.next_task = lts_pkg::IdleId;
                    end else begin
                        r.next_task    = draw_winner(ev.draw);
                        r.drew_lottery = 1;
                    end
                end
                default: ;
            endcase
            running = r.next_task;
            expected_q.push_back(r);
        endfunction

        task check_result(lts_pkg::t_out got);
            lts_pkg::t_out e;
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing expected", got, got);
                return;
            end
            e = expected_q.pop_front();
            if (got.next_task !== e.next_task) report_mismatch("next_task", got, e);
            if (got.drew_lottery !== e.drew_lottery) report_mismatch("drew_lottery", got, e);
            if (got.status !== e.status) report_mismatch("status", got, e);
        endtask

        task report_mismatch(string what, lts_pkg::t_out got, lts_pkg::t_out e);
            $display({"MISMATCH %s: got task %0d drew %0d status %0d,",
                      " exp task %0d drew %0d status %0d"},
                     what, got.next_task, got.drew_lottery, got.status,
                     e.next_task, e.drew_lottery, e.status);
            errors++;
        endtask
    endclass

    localparam int StallLimit = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    lts_pkg::t_in  i_item;
    logic        o_done;
    lts_pkg::t_out o_result;
    logic        i_cfg_we;
    logic [9:0]  i_cfg_data;

    sched_scoreboard sb;
    int          idle_cycles;
    bit          allow_unblock;

    lottery_task_scheduler_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // results are registered outputs, so sampling at the edge is race-free
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_result);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > StallLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_event(logic [2:0] act, logic [7:0] id, logic [31:0] draw);
        lts_pkg::t_in ev;
        int  gap;
        int  pick;
        ev.action  = act;
        ev.task_id = id;
        ev.draw    = draw;
        start  <= 1'b1;
        i_item <= ev;
        do @(posedge i_clk); while (busy);
        sb.note_event(ev);
        pick = $urandom_range(0, 99);
        if (pick < 65) gap = 0;
        else if (pick < 95) gap = $urandom_range(1, 4);
        else gap = $urandom_range(10, 80);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0 || busy) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_quantum(logic [9:0] q);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= q;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.quantum = q;
    endtask

    function automatic logic [7:0] pick_id();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 23));
    endfunction

    function automatic logic [31:0] pick_draw();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return 32'd0;
        if (p == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic random_events(int n);
        int p;
        logic [2:0] act;
        for (int k = 0; k < n; k++) begin
            p = $urandom_range(0, 99);
            if (p < 40) act = lts_pkg::ACT_TICK;
            else if (p < 60) act = lts_pkg::ACT_LOAD;
            else if (p < 75) act = allow_unblock ? lts_pkg::ACT_UNBLOCK : lts_pkg::ACT_LOAD;
            else if (p < 87) act = lts_pkg::ACT_BLOCK;
            else if (p < 95) act = lts_pkg::ACT_EXIT;
            else act = 3'($urandom_range(5, 7));
            send_event(act, pick_id(), pick_draw());
        end
    endtask

    initial begin
        sb            = new();
        idle_cycles   = 0;
        allow_unblock = 1;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_item        = '0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle corners, extreme ids and draws, unknown actions
        send_event(lts_pkg::ACT_TICK, 8'd0, 32'd0);
        send_event(lts_pkg::ACT_EXIT, 8'd0, 32'd5);
        send_event(lts_pkg::ACT_BLOCK, 8'd0, 32'd5);
        send_event(lts_pkg::ACT_LOAD, 8'd0, 32'd0);
        send_event(lts_pkg::ACT_LOAD, 8'd255, 32'hFFFF_FFFF);
        send_event(lts_pkg::ACT_LOAD, 8'd170, 32'd0);
        send_event(lts_pkg::ACT_TICK, 8'd85, 32'hFFFF_FFFF);
        send_event(lts_pkg::ACT_TICK, 8'd0, 32'd1);
        send_event(lts_pkg::ACT_BLOCK, 8'd0, 32'd7);
        send_event(lts_pkg::ACT_UNBLOCK, 8'd0, 32'd0);
        send_event(lts_pkg::ACT_UNBLOCK, 8'd170, 32'd0);
        send_event(3'd5, 8'hFF, 32'hFFFF_FFFF);
        send_event(3'd6, 8'd0, 32'd0);
        send_event(3'd7, 8'd1, 32'd1);
        send_event(lts_pkg::ACT_TICK, 8'd0, 32'd12345);
        send_event(lts_pkg::ACT_EXIT, 8'd0, 32'd3);
        send_event(lts_pkg::ACT_EXIT, 8'd0, 32'd9);
        send_event(lts_pkg::ACT_EXIT, 8'd0, 32'd2);
        send_event(lts_pkg::ACT_EXIT, 8'd0, 32'd2);
        send_event(lts_pkg::ACT_TICK, 8'd0, 32'd0);

        random_events(400);
        set_quantum(10'd1);
        random_events(250);
        // no unblocks here so the compensation table fills up
        allow_unblock = 0;
        set_quantum(10'd1023);
        random_events(300);
        allow_unblock = 1;
        random_events(100);
        set_quantum(10'd0);
        random_events(200);
        set_quantum(10'd3);
        random_events(250);
        set_quantum(10'($urandom_range(2, 40)));
        random_events(200);

        drain();
        if (sb.errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
